>>> design/vcsd_pkg.sv
// shared types, constants and helper functions of the vehicle can signal decoder
package vcsd_pkg;

  localparam int unsigned RATIO_FRAC_BITS = 8;

  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [10:0] ID_THROTTLE = 11'h17C;
  localparam logic [10:0] ID_RPM      = 11'h1DC;
  localparam logic [10:0] ID_SPEED    = 11'h158;
  localparam logic [10:0] ID_LAMPS    = 11'h1A6;
  localparam logic [10:0] ID_GEAR     = 11'h13C;
  localparam logic [10:0] ID_SIGNALS  = 11'h294;
  localparam logic [10:0] ID_TEMPS    = 11'h324;
  localparam logic [10:0] ID_VTEC     = 11'h320;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_RPM_ON,
    CFG_RPM_OFF,
    CFG_THR_ON,
    CFG_THR_OFF
  } cfg_index_e;

  localparam int unsigned LB_REVERSE = 0;
  localparam int unsigned LB_AC      = 1;
  localparam int unsigned LB_BRAKE   = 2;
  localparam int unsigned LB_CRUISE  = 3;
  localparam int unsigned LB_RIGHT   = 4;
  localparam int unsigned LB_LEFT    = 5;
  localparam int unsigned LB_WIPER   = 6;
  localparam int unsigned LB_CLUTCH  = 7;

  localparam logic [3:0] GEAR_NEUTRAL = 4'd0;
  localparam logic [3:0] GEAR_REVERSE = 4'd7;
  localparam logic [3:0] GEAR_CLUTCH  = 4'd8;

  localparam logic [2:0] HL_UNKNOWN = 3'd4;

  // 0.074673 in q0.24
  localparam logic [20:0] RATIO_K = 21'd1252805;

  localparam int unsigned WIN_N = 6;
  localparam logic [23:0] WIN_LO [WIN_N] = '{
    24'd917229, 24'd572743, 24'd401201, 24'd301253, 24'd233028, 24'd181649
  };
  localparam logic [23:0] WIN_HI [WIN_N] = '{
    24'd1121058, 24'd700019, 24'd490356, 24'd368198, 24'd284812, 24'd222016
  };

  typedef struct packed {
    logic [4:0]  pad;
    logic [7:0]  byte7;
    logic [7:0]  byte6;
    logic [7:0]  byte5;
    logic [7:0]  byte4;
    logic [7:0]  byte3;
    logic [7:0]  byte2;
    logic [7:0]  byte1;
    logic [7:0]  byte0;
    logic [10:0] frame_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        pad;
    logic signed [8:0] intake_temp;
    logic signed [8:0] water_temp;
    logic [2:0]        headlight_mode;
    logic [7:0]        lamp_bits;
    logic [3:0]        gear_code;
    logic [8:0]        road_speed;
    logic [6:0]        throttle_pct;
    logic [15:0]       engine_rpm;
    logic              vtec_seen;
    logic              rpm_high;
    logic              throttle_high;
    logic              exhaust_open;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic decode;
    logic mul;
    logic init;
    logic step;
    logic win;
    logic emit;
  } vcsd_cmd_t;

  typedef struct packed {
    logic need_est;
    logic out_free;
  } vcsd_stat_t;

  // raw / 654 as (raw >> 1) * ceil(2^23 / 327) >> 23
  function automatic logic [6:0] throttle_div(input logic [15:0] raw);
    logic [29:0] prod;
    prod = raw[15:1] * 15'd25654;
    return prod[29:23];
  endfunction

  // raw / 160 as (raw >> 5) * ceil(2^14 / 5) >> 14
  function automatic logic [8:0] speed_div(input logic [15:0] raw);
    logic [22:0] prod;
    prod = raw[15:5] * 12'd3277;
    return prod[22:14];
  endfunction

endpackage

>>> design/vcsd_ctrl.sv
// control state machine sequencing decode, ratio division and result hand-off
module vcsd_ctrl #(
  parameter int unsigned RatioFracBits = vcsd_pkg::RATIO_FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_tvalid_i,
  output logic                 in_tready_o,
  input  vcsd_pkg::vcsd_stat_t stat_i,
  output vcsd_pkg::vcsd_cmd_t  cmd_o
);
  import vcsd_pkg::*;

  localparam int unsigned QW    = 8 + RatioFracBits;
  localparam int unsigned CNT_W = $clog2(QW);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL,
    ST_INIT,
    ST_DIV,
    ST_WIN,
    ST_EMIT
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == ST_IDLE) && in_tvalid_i;
    cmd_o.decode = (state_q == ST_DECODE);
    cmd_o.mul    = (state_q == ST_MUL);
    cmd_o.init   = (state_q == ST_INIT);
    cmd_o.step   = (state_q == ST_DIV);
    cmd_o.win    = (state_q == ST_WIN);
    cmd_o.emit   = (state_q == ST_EMIT) && stat_i.out_free;
  end

  assign in_tready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_tvalid_i) begin
            state_q <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          state_q <= stat_i.need_est ? ST_MUL : ST_EMIT;
        end
        ST_MUL: begin
          state_q <= ST_INIT;
        end
        ST_INIT: begin
          state_q <= ST_DIV;
          cnt_q   <= '0;
        end
        ST_DIV: begin
          if (cnt_q == CNT_W'(QW - 1)) begin
            state_q <= ST_WIN;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_WIN: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (stat_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          cnt_q   <= '0;
        end
      endcase
    end
  end

  a_load_then_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_DECODE)
    else $error("accepted frame not followed by decode");

  a_cnt_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_DIV |-> cnt_q == '0)
    else $error("division counter running outside division");

  a_emit_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> state_q == ST_IDLE && !cmd_o.decode)
    else $error("emit not followed by idle");

endmodule

>>> design/vcsd_datapath.sv
// frame capture, signal decode, snapshot registers, ratio divider and result register
module vcsd_datapath #(
  parameter int unsigned RatioFracBits = vcsd_pkg::RATIO_FRAC_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  vcsd_pkg::vcsd_cmd_t                  cmd_i,
  output vcsd_pkg::vcsd_stat_t                 stat_o,
  input  logic [vcsd_pkg::IN_TDATA_W-1:0]      in_tdata_i,
  input  logic                                 cfg_we_i,
  input  logic [vcsd_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [vcsd_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  output logic [vcsd_pkg::OUT_TDATA_W-1:0]     out_tdata_o,
  output logic                                 out_tvalid_o,
  input  logic                                 out_tready_i
);
  import vcsd_pkg::*;

  localparam int unsigned QW     = 8 + RatioFracBits;
  localparam int unsigned PROD_W = 37;
  localparam int unsigned SHIFT  = 24 - RatioFracBits;
  localparam int unsigned NUMT_W = PROD_W - SHIFT;

  localparam logic [7:0] CRUISE_ON      = 8'h48;
  localparam logic [7:0] BRAKE_ON       = 8'h20;
  localparam logic [7:0] CLUTCH_RELEASE = 8'h04;
  localparam logic [3:0] NIB_REVERSE    = 4'h4;
  localparam logic [3:0] NIB_AC         = 4'h4;
  localparam logic [3:0] NIB_RIGHT      = 4'h4;
  localparam logic [3:0] NIB_LEFT       = 4'h2;
  localparam logic [3:0] NIB_WIPER      = 4'hC;

  in_item_t          frame_q;
  logic [15:0]       rpm_on_q, rpm_off_q;
  logic [6:0]        thr_on_q, thr_off_q;

  logic              thr_flag_q, thr_flag_d;
  logic              rpm_hi_q, rpm_hi_d;
  logic [15:0]       rpm_q, rpm_d;
  logic [6:0]        thr_q, thr_d;
  logic [8:0]        speed_q, speed_d;
  logic [3:0]        gear_q, gear_d;
  logic [7:0]        lamp_q, lamp_d;
  logic [2:0]        head_q, head_d;
  logic [8:0]        water_q, water_d;
  logic [8:0]        intake_q, intake_d;

  logic [NUMT_W-1:0] numt_q;
  logic [8:0]        rem_q;
  logic [QW-1:0]     acc_q;
  logic              sat_q;

  out_item_t         out_q;
  logic              out_valid_q;

  logic [PROD_W-1:0] prod;
  logic [9:0]        trial;
  logic [9:0]        diff;
  logic              ge;
  logic [QW-1:0]     quot;
  logic [23:0]       r16;
  logic [3:0]        win_gear;
  logic [3:0]        nib;

  assign stat_o.need_est = (frame_q.frame_id == ID_GEAR) && !lamp_q[LB_REVERSE]
                           && (frame_q.byte6 == CLUTCH_RELEASE) && (speed_q != '0);
  assign stat_o.out_free = !out_valid_q || out_tready_i;

  // ratio divider datapath
  assign prod  = rpm_q * RATIO_K;
  assign trial = {rem_q, acc_q[QW-1]};
  assign diff  = trial - {1'b0, speed_q};
  assign ge    = trial >= {1'b0, speed_q};
  assign quot  = sat_q ? '1 : acc_q;
  assign r16   = 24'(quot) << (16 - RatioFracBits);

  always_comb begin
    win_gear = GEAR_NEUTRAL;
    for (int i = WIN_N - 1; i >= 0; i--) begin
      if (r16 > WIN_LO[i] && r16 < WIN_HI[i]) begin
        win_gear = 4'(i + 1);
      end
    end
  end

  always_comb begin
    thr_flag_d = thr_flag_q;
    rpm_hi_d   = rpm_hi_q;
    rpm_d      = rpm_q;
    thr_d      = thr_q;
    speed_d    = speed_q;
    gear_d     = gear_q;
    lamp_d     = lamp_q;
    head_d     = head_q;
    water_d    = water_q;
    intake_d   = intake_q;
    nib        = frame_q.byte0[3:0];
    if (cmd_i.decode) begin
      case (frame_q.frame_id)
        ID_THROTTLE: begin
          thr_d = throttle_div({frame_q.byte0, frame_q.byte1});
          if (thr_d > thr_on_q) begin
            thr_flag_d = 1'b1;
          end else if (thr_d < thr_off_q) begin
            thr_flag_d = 1'b0;
          end
          lamp_d[LB_CRUISE] = (frame_q.byte4 == CRUISE_ON);
          lamp_d[LB_BRAKE]  = (frame_q.byte6 == BRAKE_ON);
        end
        ID_RPM: begin
          rpm_d = {frame_q.byte1, frame_q.byte2};
          if (rpm_d > rpm_on_q) begin
            rpm_hi_d = 1'b1;
          end else if (rpm_d < rpm_off_q) begin
            rpm_hi_d = 1'b0;
          end
        end
        ID_SPEED: begin
          speed_d = speed_div({frame_q.byte0, frame_q.byte1});
        end
        ID_LAMPS: begin
          lamp_d[LB_REVERSE] = (frame_q.byte2[3:0] == NIB_REVERSE);
          lamp_d[LB_AC]      = (frame_q.byte2[7:4] == NIB_AC);
          head_d             = nib[3] ? HL_UNKNOWN : {1'b0, nib[1:0]};
        end
        ID_GEAR: begin
          if (lamp_q[LB_REVERSE]) begin
            gear_d = GEAR_REVERSE;
          end else if (frame_q.byte6 != CLUTCH_RELEASE) begin
            lamp_d[LB_CLUTCH] = 1'b1;
            gear_d            = GEAR_CLUTCH;
          end else begin
            lamp_d[LB_CLUTCH] = 1'b0;
            if (speed_q == '0) begin
              gear_d = GEAR_NEUTRAL;
            end
          end
        end
        ID_SIGNALS: begin
          lamp_d[LB_RIGHT] = (frame_q.byte0[7:4] == NIB_RIGHT);
          lamp_d[LB_LEFT]  = (frame_q.byte0[7:4] == NIB_LEFT);
          lamp_d[LB_WIPER] = (frame_q.byte0[3:0] == NIB_WIPER);
        end
        ID_TEMPS: begin
          water_d  = {1'b0, frame_q.byte0} - 9'd40;
          intake_d = {1'b0, frame_q.byte1} - 9'd40;
        end
        default: ;
      endcase
    end
    if (cmd_i.win) begin
      gear_d = win_gear;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rpm_on_q    <= 16'd5000;
      rpm_off_q   <= 16'd4800;
      thr_on_q    <= 7'd50;
      thr_off_q   <= 7'd45;
      thr_flag_q  <= 1'b0;
      rpm_hi_q    <= 1'b0;
      rpm_q       <= '0;
      thr_q       <= '0;
      speed_q     <= '0;
      gear_q      <= GEAR_NEUTRAL;
      lamp_q      <= '0;
      head_q      <= '0;
      water_q     <= '0;
      intake_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_e'(cfg_index_i))
          CFG_RPM_ON:  rpm_on_q  <= cfg_wdata_i;
          CFG_RPM_OFF: rpm_off_q <= cfg_wdata_i;
          CFG_THR_ON:  thr_on_q  <= cfg_wdata_i[6:0];
          CFG_THR_OFF: thr_off_q <= cfg_wdata_i[6:0];
          default: ;
        endcase
      end
      thr_flag_q <= thr_flag_d;
      rpm_hi_q   <= rpm_hi_d;
      rpm_q      <= rpm_d;
      thr_q      <= thr_d;
      speed_q    <= speed_d;
      gear_q     <= gear_d;
      lamp_q     <= lamp_d;
      head_q     <= head_d;
      water_q    <= water_d;
      intake_q   <= intake_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      frame_q <= in_tdata_i;
    end
    if (cmd_i.mul) begin
      numt_q <= prod[PROD_W-1:SHIFT];
    end
    if (cmd_i.init) begin
      sat_q <= 9'(numt_q[NUMT_W-1:QW]) >= speed_q;
      rem_q <= 9'(numt_q[NUMT_W-1:QW]);
      acc_q <= numt_q[QW-1:0];
    end
    if (cmd_i.step) begin
      rem_q <= ge ? diff[8:0] : trial[8:0];
      acc_q <= {acc_q[QW-2:0], ge};
    end
    if (cmd_i.emit) begin
      out_q.pad            <= '0;
      out_q.exhaust_open   <= thr_flag_q & rpm_hi_q & (frame_q.frame_id == ID_VTEC);
      out_q.throttle_high  <= thr_flag_q;
      out_q.rpm_high       <= rpm_hi_q;
      out_q.vtec_seen      <= (frame_q.frame_id == ID_VTEC);
      out_q.engine_rpm     <= rpm_q;
      out_q.throttle_pct   <= thr_q;
      out_q.road_speed     <= speed_q;
      out_q.gear_code      <= gear_q;
      out_q.lamp_bits      <= lamp_q;
      out_q.headlight_mode <= head_q;
      out_q.water_temp     <= water_q;
      out_q.intake_temp    <= intake_q;
    end
  end

  assign out_tdata_o  = out_q;
  assign out_tvalid_o = out_valid_q;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step && !sat_q |-> rem_q < speed_q)
    else $error("partial remainder not below divisor");

  a_exhaust_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !out_q.exhaust_open
                    || (out_q.vtec_seen && out_q.throttle_high && out_q.rpm_high))
    else $error("exhaust open without its conditions");

  a_est_only_gear_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mul |-> frame_q.frame_id == ID_GEAR && speed_q != '0)
    else $error("ratio estimate started for wrong frame");

endmodule

>>> design/vehicle_can_signal_decoder.sv
// top level of the vehicle can signal decoder
//
// input stream: one transaction per received frame, tdata carries the 11-bit
// identifier and eight data bytes; every frame yields exactly one output
// transaction holding the updated vehicle snapshot (rpm, throttle, speed,
// gear, lamp bits, headlight mode, temperatures and the hysteresis flags)
// configuration: single-cycle writes of the rpm and throttle on/off levels,
// to be done while no frame is in flight
// sequence: a plain frame is captured, decoded and then handed to the output
// register; a gear frame that needs the ratio estimate passes through multiply,
// divider init, division and gear window steps before the hand-off, the restoring
// divider retiring one quotient bit per cycle
// one frame is in work at a time; tready rises again once its result sits
// in the output register, so the next frame is taken while that result waits
// a stalled receiver holds the result; a finished frame then waits in the
// hand-off state until the output register frees
// reset: snapshot cleared to zero (gear neutral, headlights off) and levels
// back to 5000/4800 rpm and 50/45 percent
module vehicle_can_signal_decoder #(
  parameter int unsigned RatioFracBits = vcsd_pkg::RATIO_FRAC_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // frame_id, byte0 .. byte7, zero pad
  input  logic [vcsd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // exhaust_open, throttle_high, rpm_high, vtec_seen, engine_rpm, throttle_pct,
  // road_speed, gear_code, lamp_bits, headlight_mode, water_temp, intake_temp, zero pad
  output logic [vcsd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                 cfg_we_i,
  input  logic [vcsd_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [vcsd_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import vcsd_pkg::*;

  vcsd_cmd_t  cmd;
  vcsd_stat_t stat;

  vcsd_ctrl #(
    .RatioFracBits(RatioFracBits)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_tvalid_i(s_axis_tvalid),
    .in_tready_o(s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  vcsd_datapath #(
    .RatioFracBits(RatioFracBits)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_tdata_i  (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_tdata_o (m_axis_tdata),
    .out_tvalid_o(m_axis_tvalid),
    .out_tready_i(m_axis_tready)
  );

endmodule
